FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A check that holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A check whose consequent follows its trigger in the next cycle.
`define ASSERT_NEXT(label, clk, rst, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error(msg);

`endif

FILE: rtl/frc_pkg.sv
// Package with the shared types and constants of the frame receiver.
`timescale 1ns / 1ps

package frc_pkg;

  // Fixed frame markers and the reset value of the second head byte.
  localparam logic [7:0] HeadFirst = 8'hFA;
  localparam logic [7:0] TailByte  = 8'hFC;
  localparam logic [7:0] HeadReset = 8'h5A;

  // Frame verdict codes.
  localparam logic [1:0] StatusNone = 2'd0;
  localparam logic [1:0] StatusGood = 2'd1;
  localparam logic [1:0] StatusBad  = 2'd2;

  // One result beat.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [1:0] frame_status;
    logic [7:0] frame_cmd;
    logic [7:0] frame_len;
  } frc_result_t;

endpackage

FILE: rtl/frc_if.sv
// Handshake interfaces for the received-byte and result channels.
`timescale 1ns / 1ps

interface frc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface frc_res_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [1:0] frame_status;
  logic [7:0] frame_cmd;
  logic [7:0] frame_len;

  modport source (
    output valid, output payload_valid, output payload_byte, output payload_index,
    output frame_status, output frame_cmd, output frame_len, input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input payload_index,
    input frame_status, input frame_cmd, input frame_len, output ready
  );
endinterface

FILE: rtl/frc_parser.sv
// Frame parser: phase register, length, count and checksum state, and result logic.
`timescale 1ns / 1ps

module frc_parser #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  output frc_pkg::frc_result_t result
);
  import frc_pkg::*;

  localparam int OverheadBytes = 8;
  localparam int CountWidth    = $clog2(MAX_FRAME_BYTES);
  localparam logic [15:0] MaxPayload = 16'(MAX_FRAME_BYTES - OverheadBytes);

  typedef enum logic [3:0] {
    PH_HEAD1  = 4'd0,
    PH_HEAD2  = 4'd1,
    PH_LEN_LO = 4'd2,
    PH_LEN_HI = 4'd3,
    PH_CMD    = 4'd4,
    PH_DATA   = 4'd5,
    PH_SUM_LO = 4'd6,
    PH_SUM_HI = 4'd7,
    PH_TAIL   = 4'd8
  } phase_t;

  phase_t                phase, phase_next;
  logic [7:0]            head_byte;
  logic [15:0]           frame_length, frame_length_next;
  logic [CountWidth-1:0] byte_count, byte_count_next;
  logic [CountWidth-1:0] count_inc;
  logic [15:0]           count_ext;
  logic [7:0]            command_reg, command_reg_next;
  logic [15:0]           running_sum, running_sum_next;
  logic [15:0]           received_sum, received_sum_next;
  logic [15:0]           sum_add;
  logic [15:0]           length_hi;

  assign sum_add   = running_sum + 16'(rx_byte);
  assign count_inc = byte_count + CountWidth'(1);
  assign count_ext = 16'(byte_count);
  assign length_hi = {rx_byte, frame_length[7:0]};

  // Next state and the result of the current byte.
  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    byte_count_next   = byte_count;
    command_reg_next  = command_reg;
    running_sum_next  = running_sum;
    received_sum_next = received_sum;
    result            = '0;
    unique case (phase)
      PH_HEAD2: begin
        if (rx_byte == head_byte) begin
          running_sum_next = sum_add;
          phase_next       = PH_LEN_LO;
        end else if (rx_byte != HeadFirst) begin
          phase_next = PH_HEAD1;
        end
      end
      PH_LEN_LO: begin
        frame_length_next = 16'(rx_byte);
        running_sum_next  = sum_add;
        phase_next        = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_length_next = length_hi;
        running_sum_next  = sum_add;
        phase_next        = (length_hi > MaxPayload) ? PH_HEAD1 : PH_CMD;
      end
      PH_CMD: begin
        command_reg_next = rx_byte;
        running_sum_next = sum_add;
        byte_count_next  = '0;
        phase_next       = (frame_length != 16'd0) ? PH_DATA : PH_SUM_LO;
      end
      PH_DATA: begin
        result.payload_valid = 1'b1;
        result.payload_byte  = rx_byte;
        result.payload_index = count_ext[7:0];
        running_sum_next     = sum_add;
        byte_count_next      = count_inc;
        if (16'(count_inc) >= frame_length) begin
          phase_next = PH_SUM_LO;
        end
      end
      PH_SUM_LO: begin
        received_sum_next = 16'(rx_byte);
        phase_next        = PH_SUM_HI;
      end
      PH_SUM_HI: begin
        received_sum_next = {rx_byte, received_sum[7:0]};
        phase_next        = PH_TAIL;
      end
      PH_TAIL: begin
        if (rx_byte == TailByte) begin
          result.frame_status = (received_sum == running_sum) ? StatusGood : StatusBad;
          result.frame_cmd    = command_reg;
          result.frame_len    = frame_length[7:0];
          phase_next          = PH_HEAD1;
        end else if (rx_byte == HeadFirst) begin
          running_sum_next = 16'(HeadFirst);
          phase_next       = PH_HEAD2;
        end else begin
          phase_next = PH_HEAD1;
        end
      end
      default: begin
        // Hunting for the first head byte; unused codes behave the same.
        if (rx_byte == HeadFirst) begin
          running_sum_next = 16'(HeadFirst);
          phase_next       = PH_HEAD2;
        end else begin
          phase_next = PH_HEAD1;
        end
      end
    endcase
  end

  // Parse state registers advance only on an accepted beat; the head byte loads on cfg_wr_en.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEAD1;
      head_byte    <= HeadReset;
      frame_length <= '0;
      byte_count   <= '0;
      command_reg  <= '0;
      running_sum  <= '0;
      received_sum <= '0;
    end else begin
      if (cfg_wr_en) begin
        head_byte <= cfg_wr_data;
      end
      if (accept) begin
        phase        <= phase_next;
        frame_length <= frame_length_next;
        byte_count   <= byte_count_next;
        command_reg  <= command_reg_next;
        running_sum  <= running_sum_next;
        received_sum <= received_sum_next;
      end
    end
  end

endmodule

FILE: rtl/frc_out_buf.sv
// Result register with a skid stage, so that a stalled receiver costs no input beat.
`timescale 1ns / 1ps

module frc_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  frc_pkg::frc_result_t push_data,
  output logic                 push_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output frc_pkg::frc_result_t out_data
);
  import frc_pkg::*;

  logic        main_valid;
  frc_result_t main_data;
  logic        skid_valid;
  frc_result_t skid_data;

  assign push_ready = !skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;

  // Control: the skid stage fills only while the result register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !main_valid) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    if (out_ready || !main_valid) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

FILE: rtl/frame_receiver_checksum_check_core.sv
// Top level of the serial frame receiver with additive checksum check.
`timescale 1ns / 1ps
// Usage
// The rx channel takes one received byte per beat. The result channel gives
// exactly one beat for every byte taken: the payload byte and its index when
// the byte lay in a frame's payload, or the verdict, command and length on a
// frame's tail byte, and all zero otherwise.
// The expected second head byte is written through cfg_wr_en and cfg_wr_data
// while the block is idle; reset sets it to 0x5A.
// Throughput is one byte per cycle while the receiver takes results, set by
// the phase register and the single result register that follows the parse
// logic. When the receiver stalls, one more byte is caught in the skid stage,
// and rx.ready then falls until the result register drains.
// Reset (synchronous, active high) returns the parser to hunting for 0xFA,
// clears the checksum state and empties both output stages.
module frame_receiver_checksum_check_core #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  frc_rx_if.sink     rx,
  frc_res_if.source  result
);
  import frc_pkg::*;

  logic        rx_accept;
  frc_result_t parse_result;
  frc_result_t out_data;

  assign rx_accept = rx.valid && rx.ready;

  // Parser state and per-byte result.
  frc_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .accept     (rx_accept),
    .rx_byte    (rx.rx_byte),
    .result     (parse_result)
  );

  // Result register and skid stage.
  frc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (rx_accept),
    .push_data (parse_result),
    .push_ready(rx.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  // Result fields onto the channel.
  assign result.payload_valid = out_data.payload_valid;
  assign result.payload_byte  = out_data.payload_byte;
  assign result.payload_index = out_data.payload_index;
  assign result.frame_status  = out_data.frame_status;
  assign result.frame_cmd     = out_data.frame_cmd;
  assign result.frame_len     = out_data.frame_len;

  `include "assert_macros.svh"

  // Back-pressure on rx only arises while a result waits.
  `ASSERT_ALWAYS(a_ready_implies_pending, clk, rst, rx.ready || result.valid, "rx stalled with empty output")
  // After every accepted byte, a result beat is valid in the next cycle.
  `ASSERT_NEXT(a_accept_gives_result, clk, rst, rx.valid && rx.ready, result.valid, "accepted byte produced no result")
  // A payload beat never carries a verdict.
  `ASSERT_ALWAYS(a_payload_no_verdict, clk, rst, !(result.valid && result.payload_valid && result.frame_status != StatusNone), "payload beat with verdict")
  // Verdict fields are zero without a verdict.
  `ASSERT_ALWAYS(a_no_verdict_zero, clk, rst, !(result.valid && result.frame_status == StatusNone && (result.frame_cmd != 8'd0 || result.frame_len != 8'd0)), "stray verdict fields")

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the serial frame receiver with checksum check.
`timescale 1ns / 1ps

// Frame limits, as the block is built here.
localparam int MaxFrameBytes = 256;
localparam int OverheadBytes = 8;
localparam int MaxPayload    = MaxFrameBytes - OverheadBytes;

// Parser phases of the predicted receiver.
typedef enum logic [3:0] {
  PhHead1, PhHead2, PhLenLo, PhLenHi, PhCmd, PhData, PhSumLo, PhSumHi, PhTail
} rx_phase_t;

// Shapes of the byte sequences that the stimulus sends.
typedef enum int {
  FrameGood, FrameBadSum, FrameFaTail, FrameBadTail, FrameTooLong, FrameWrongHead
} frame_kind_t;

// Predicts the result beat of every accepted byte and checks the beats that come out.
class frame_tracker;
  logic [7:0]  head_byte;
  rx_phase_t   phase;
  logic [15:0] frame_length;
  logic [15:0] byte_count;
  logic [7:0]  command;
  logic [15:0] running_sum;
  logic [15:0] received_sum;
  frc_pkg::frc_result_t expected_beats[$];
  int failures;

  function void clear();
    head_byte    = frc_pkg::HeadReset;
    phase        = PhHead1;
    frame_length = '0;
    byte_count   = '0;
    command      = '0;
    running_sum  = '0;
    received_sum = '0;
    expected_beats.delete();
    failures = 0;
  endfunction

  // Advances the parser by one accepted byte and queues the beat it should give.
  function void note_byte(logic [7:0] b);
    frc_pkg::frc_result_t r;
    r = '0;
    unique case (phase)
      PhHead2: begin
        if (b == head_byte) begin
          running_sum += {8'h00, b};
          phase = PhLenLo;
        end else if (b != frc_pkg::HeadFirst) begin
          phase = PhHead1;
        end
      end
      PhLenLo: begin
        frame_length = {8'h00, b};
        running_sum += {8'h00, b};
        phase = PhLenHi;
      end
      PhLenHi: begin
        frame_length[15:8] = b;
        running_sum += {8'h00, b};
        phase = (frame_length > MaxPayload) ? PhHead1 : PhCmd;
      end
      PhCmd: begin
        command = b;
        running_sum += {8'h00, b};
        byte_count = '0;
        phase = (frame_length > 0) ? PhData : PhSumLo;
      end
      PhData: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = byte_count[7:0];
        running_sum += {8'h00, b};
        byte_count += 16'd1;
        if (byte_count >= frame_length) phase = PhSumLo;
      end
      PhSumLo: begin
        received_sum = {8'h00, b};
        phase = PhSumHi;
      end
      PhSumHi: begin
        received_sum[15:8] = b;
        phase = PhTail;
      end
      PhTail: begin
        if (b == frc_pkg::TailByte) begin
          r.frame_status = (received_sum == running_sum) ? frc_pkg::StatusGood
                                                         : frc_pkg::StatusBad;
          r.frame_cmd = command;
          r.frame_len = frame_length[7:0];
          phase = PhHead1;
        end else if (b == frc_pkg::HeadFirst) begin
          running_sum = {8'h00, frc_pkg::HeadFirst};
          phase = PhHead2;
        end else begin
          phase = PhHead1;
        end
      end
      default: begin
        if (b == frc_pkg::HeadFirst) begin
          running_sum = {8'h00, frc_pkg::HeadFirst};
          phase = PhHead2;
        end else begin
          phase = PhHead1;
        end
      end
    endcase
    expected_beats.push_back(r);
  endfunction

  // Compares one accepted result beat with the oldest expected beat.
  function void check_beat(frc_pkg::frc_result_t got);
    frc_pkg::frc_result_t want;
    if (expected_beats.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display({"unexpected result beat: valid=%0d byte=%02h index=%0d",
                  " status=%0d cmd=%02h len=%0d"},
                 got.payload_valid, got.payload_byte, got.payload_index,
                 got.frame_status, got.frame_cmd, got.frame_len);
      return;
    end
    want = expected_beats.pop_front();
    if (got.payload_valid !== want.payload_valid || got.payload_byte !== want.payload_byte ||
        got.payload_index !== want.payload_index || got.frame_status !== want.frame_status ||
        got.frame_cmd !== want.frame_cmd || got.frame_len !== want.frame_len) begin
      failures++;
      if (failures <= 10) begin
        $display("result mismatch at %0t", $time);
        $display("  expected valid=%0d byte=%02h index=%0d status=%0d cmd=%02h len=%0d",
                 want.payload_valid, want.payload_byte, want.payload_index,
                 want.frame_status, want.frame_cmd, want.frame_len);
        $display("  actual   valid=%0d byte=%02h index=%0d status=%0d cmd=%02h len=%0d",
                 got.payload_valid, got.payload_byte, got.payload_index,
                 got.frame_status, got.frame_cmd, got.frame_len);
      end
    end
  endfunction
endclass

module testbench;
  import frc_pkg::*;

  localparam int TotalBytes   = 850;
  localparam int IdleLimit    = 1000;
  localparam int SettleCycles = 3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  frc_rx_if  rx_ch ();
  frc_res_if result_ch ();

  frame_tracker tracker;
  int bytes_sent;
  bit gaps_on;
  bit stalls_on;
  int idle_cycles;

  frame_receiver_checksum_check_core #(
    .MAX_FRAME_BYTES(MaxFrameBytes)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .rx(rx_ch.sink),
    .result(result_ch.source)
  );

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Sends one byte after a random gap and notes it once it has been taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 49) == 0) gaps_on = !gaps_on;
    gap = gaps_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    tracker.note_byte(b);
    bytes_sent++;
  endtask

  // Stops sending and waits until every expected beat has come out.
  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    while (tracker.expected_beats.size() > 0) @(posedge clk);
  endtask

  // Writes the expected second head byte while the receiver is idle.
  task automatic write_head(input logic [7:0] value);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.head_byte = value;
  endtask

  // Sends a frame, whole or broken off or damaged as the kind says.
  task automatic send_frame(input logic [7:0] head2, input logic [15:0] len,
                            input logic [7:0] cmd, input frame_kind_t kind,
                            input int extra_heads);
    logic [15:0] sum;
    logic [7:0]  b;
    logic [7:0]  tail;
    repeat (extra_heads) send_byte(HeadFirst);
    send_byte(HeadFirst);
    if (kind == FrameWrongHead) begin
      do b = 8'($urandom_range(0, 255)); while (b == head2 || b == HeadFirst);
      send_byte(b);
      return;
    end
    sum = 16'(HeadFirst) + 16'(head2) + 16'(len[7:0]) + 16'(len[15:8]) + 16'(cmd);
    send_byte(head2);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (kind == FrameTooLong) return;
    send_byte(cmd);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      sum += 16'(b);
      send_byte(b);
    end
    if (kind == FrameBadSum) sum ^= 16'($urandom_range(1, 65535));
    send_byte(sum[7:0]);
    send_byte(sum[15:8]);
    unique case (kind)
      FrameFaTail: tail = HeadFirst;
      FrameBadTail: begin
        do tail = 8'($urandom_range(0, 255)); while (tail == TailByte || tail == HeadFirst);
      end
      default: tail = TailByte;
    endcase
    send_byte(tail);
  endtask

  // Result side: random stalls, then every beat is checked.
  initial begin
    int stall;
    frc_result_t got;
    result_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) stalls_on = !stalls_on;
      stall = stalls_on ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      got.payload_valid = result_ch.payload_valid;
      got.payload_byte  = result_ch.payload_byte;
      got.payload_index = result_ch.payload_index;
      got.frame_status  = result_ch.frame_status;
      got.frame_cmd     = result_ch.frame_cmd;
      got.frame_len     = result_ch.frame_len;
      tracker.check_beat(got);
    end
  end

  // Stimulus: directed frames, then random phases under several head settings.
  initial begin
    logic [7:0]  head_choices [6];
    logic [15:0] len;
    int          pick;
    int          phase_end;
    bit          max_frame_sent;
    tracker = new();
    tracker.clear();
    bytes_sent     = 0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    max_frame_sent = 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the head byte left at its reset value: a repeated
    // first head with an empty payload, a bad checksum, an oversized length
    // and a wrong second head.
    send_frame(HeadReset, 16'd0, 8'h00, FrameGood, 1);
    send_frame(HeadReset, 16'd2, 8'hFF, FrameBadSum, 0);
    send_frame(HeadReset, 16'hFFFF, 8'h00, FrameTooLong, 0);
    send_frame(HeadReset, 16'd0, 8'h00, FrameWrongHead, 0);

    // Random phases, each under its own second head byte.
    head_choices = '{8'h5B, HeadFirst, 8'h00, 8'hFF, 8'h00, HeadReset};
    head_choices[4] = 8'($urandom_range(0, 255));
    for (int p = 0; p < 6; p++) begin
      write_head(head_choices[p]);
      phase_end = TotalBytes * (p + 1) / 6;
      while (bytes_sent < phase_end) begin
        len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, MaxPayload))
                                           : 16'($urandom_range(0, 8));
        if (!max_frame_sent) begin
          // One frame of the largest payload allowed.
          send_frame(tracker.head_byte, 16'(MaxPayload), 8'($urandom_range(0, 255)),
                     FrameGood, 0);
          max_frame_sent = 1'b1;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 94) begin
            if (pick >= 82 && pick < 88)
              len = $urandom_range(0, 1) ? {8'h00, 8'($urandom_range(MaxPayload + 1, 255))}
                                         : {8'($urandom_range(1, 255)),
                                            8'($urandom_range(0, 255))};
            send_frame(tracker.head_byte, len, 8'($urandom_range(0, 255)),
                       pick < 60 ? FrameGood :
                       pick < 70 ? FrameBadSum :
                       pick < 76 ? FrameFaTail :
                       pick < 82 ? FrameBadTail :
                       pick < 88 ? FrameTooLong : FrameWrongHead,
                       ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
          end else begin
            // Line noise between frames.
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
          end
        end
        // Now and then the sender holds off until the receiver has caught up.
        if ($urandom_range(0, 59) == 0) wait_drained();
      end
    end

    // Drain, let the pipeline settle, then give the verdict.
    wait_drained();
    repeat (20) @(posedge clk);
    if (tracker.expected_beats.size() > 0)
      $display("%0d expected result beats never arrived", tracker.expected_beats.size());
    if (tracker.failures == 0 && tracker.expected_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: frame_receiver_checksum_check_core.f
+incdir+rtl
rtl/frc_pkg.sv
rtl/frc_if.sv
rtl/frc_parser.sv
rtl/frc_out_buf.sv
rtl/frame_receiver_checksum_check_core.sv
sim/testbench.sv
